// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker of the wheel mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define MWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/mwm_pkg.sv
// Package of the wheel mixer: types, constants and the angle table.
package mwm_pkg;

    localparam logic [14:0] DZ_RESET = 15'd4915;
    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
    localparam logic [3:0] CORDIC_LAST = 4'd15;
    localparam logic [3:0] DIV_LAST = 4'd7;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] r;
        logic [15:0]        rmag;
        logic               trans_dead;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_MUL1,
        ST_MUL2,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } t_state;

    // Arctangent of 2^-i as a fraction of a turn, scaled by 65536.
    function automatic logic [13:0] turn_table(input logic [3:0] idx);
        logic [13:0] val;
        unique case (idx)
            4'd0:  val = 14'd8192;
            4'd1:  val = 14'd4836;
            4'd2:  val = 14'd2555;
            4'd3:  val = 14'd1297;
            4'd4:  val = 14'd651;
            4'd5:  val = 14'd326;
            4'd6:  val = 14'd163;
            4'd7:  val = 14'd81;
            4'd8:  val = 14'd41;
            4'd9:  val = 14'd20;
            4'd10: val = 14'd10;
            4'd11: val = 14'd5;
            4'd12: val = 14'd3;
            4'd13: val = 14'd1;
            4'd14: val = 14'd1;
            default: val = 14'd0;
        endcase
        return val;
    endfunction

endpackage

// File: hdl/mwm_in_if.sv
// Stick sample channel: three axes with valid and ready.
interface mwm_in_if #(parameter int AXIS_BITS = 16) ();
    logic                        valid;
    logic                        ready;
    logic signed [AXIS_BITS-1:0] joy_x;
    logic signed [AXIS_BITS-1:0] joy_y;
    logic signed [AXIS_BITS-1:0] joy_r;

    modport source (output valid, joy_x, joy_y, joy_r, input ready);
    modport sink (input valid, joy_x, joy_y, joy_r, output ready);
endinterface

// File: hdl/mwm_out_if.sv
// Wheel drive channel: four signed drive values with valid and ready.
interface mwm_out_if ();
    logic              valid;
    logic              ready;
    logic signed [8:0] drive_right_front;
    logic signed [8:0] drive_right_rear;
    logic signed [8:0] drive_left_rear;
    logic signed [8:0] drive_left_front;

    modport source (output valid, drive_right_front, drive_right_rear, drive_left_rear,
                    drive_left_front, input ready);
    modport sink (input valid, drive_right_front, drive_right_rear, drive_left_rear,
                  drive_left_front, output ready);
endinterface

// File: hdl/mwm_cfg_if.sv
// Configuration write channel carrying the dead zone register.
interface mwm_cfg_if ();
    logic        valid;
    logic        ready;
    logic [14:0] dead_zone;

    modport source (output valid, dead_zone, input ready);
    modport sink (input valid, dead_zone, output ready);
endinterface

// File: hdl/mwm_front.sv
// Front end: takes stick samples, scales them to Q1.15 and applies the dead zones.
module mwm_front #(
    parameter int AXIS_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [AXIS_BITS-1:0] i_joy_x,
    input  logic signed [AXIS_BITS-1:0] i_joy_y,
    input  logic signed [AXIS_BITS-1:0] i_joy_r,
    input  logic [14:0]                 i_dead_zone,
    output logic                        o_push,
    output mwm_pkg::t_cmd               o_cmd,
    input  logic                        i_full
);
    import mwm_pkg::*;

    logic signed [15:0] x16, y16, r16;
    logic [15:0]        ax, ay, ar, dz16;
    logic               r_valid;
    t_cmd               r_cmd;
    t_cmd               n_cmd;

    generate
        if (AXIS_BITS >= 16) begin : g_narrow
            assign x16 = i_joy_x[AXIS_BITS-1 -: 16];
            assign y16 = i_joy_y[AXIS_BITS-1 -: 16];
            assign r16 = i_joy_r[AXIS_BITS-1 -: 16];
        end else begin : g_widen
            assign x16 = {i_joy_x, {(16-AXIS_BITS){1'b0}}};
            assign y16 = {i_joy_y, {(16-AXIS_BITS){1'b0}}};
            assign r16 = {i_joy_r, {(16-AXIS_BITS){1'b0}}};
        end
    endgenerate

    // Full-scale negative gives 0x8000, which reads correctly as unsigned.
    assign ax   = x16[15] ? 16'(-x16) : 16'(x16);
    assign ay   = y16[15] ? 16'(-y16) : 16'(y16);
    assign ar   = r16[15] ? 16'(-r16) : 16'(r16);
    assign dz16 = {1'b0, i_dead_zone};

    always_comb begin
        n_cmd.x          = x16;
        n_cmd.y          = y16;
        n_cmd.trans_dead = (ax < dz16) && (ay < dz16);
        if (ar < dz16) begin
            n_cmd.r    = '0;
            n_cmd.rmag = '0;
        end else begin
            n_cmd.r    = r16;
            n_cmd.rmag = ar;
        end
    end

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

// File: hdl/mwm_queue.sv
// Two-word queue between the front end and the arithmetic back end.
module mwm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mwm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mwm_pkg::t_cmd o_cmd
);
    import mwm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

// File: hdl/mwm_back.sv
// Back end: magnitude and angle, wheel mixing, blending divide and the output register.
module mwm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [14:0]       i_dead_zone,
    input  logic              i_empty,
    input  mwm_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [8:0] o_drive [4]
);
    import mwm_pkg::*;

    t_state r_state, n_state;
    logic [3:0] r_cnt;
    t_cmd       r_cmd;

    // Square root and vectoring rotation run side by side.
    logic [31:0]        r_rad;
    logic [19:0]        r_rem;
    logic [15:0]        r_root;
    logic signed [33:0] r_u, r_v;
    logic signed [17:0] r_acc;

    logic [15:0]        r_mag;
    logic [31:0]        r_mm;
    logic signed [31:0] r_rr;
    logic signed [15:0] r_a, r_b;
    logic               r_blend;
    logic [16:0]        r_s;
    logic signed [48:0] r_pa, r_pb;
    logic signed [45:0] r_rt;
    logic [56:0]        r_num [4];
    logic               r_neg [4];
    logic [52:0]        r_dsh;
    logic [7:0]         r_quo [4];
    logic               r_out_valid;
    logic signed [8:0]  r_drive [4];

    logic               load_out;

    // Loading the first rotation and the sum of squares.
    logic signed [31:0] xx, yy;
    logic [31:0]        sq_sum;
    logic signed [33:0] x34, y34, u0, v0;

    // Iteration terms.
    logic [19:0]        rem_n, trial;
    logic signed [33:0] du, dv;
    logic signed [17:0] tt;

    // Mixing terms.
    logic [15:0]        mag_c;
    logic [15:0]        ang;
    logic signed [15:0] twof, a_c, b_c;
    logic [16:0]        s_c;
    logic signed [32:0] rr_w, mult;
    logic signed [49:0] num_c [4];
    logic signed [57:0] n255 [4];
    logic signed [57:0] nabs [4];

    always_comb begin
        xx     = i_cmd.x * i_cmd.x;
        yy     = i_cmd.y * i_cmd.y;
        sq_sum = unsigned'(xx) + unsigned'(yy);
        x34    = 34'(i_cmd.x);
        y34    = 34'(i_cmd.y);
        u0     = -(y34 <<< 14);
        v0     = x34 <<< 14;

        rem_n = {r_rem[17:0], r_rad[31:30]};
        trial = {2'b00, r_root, 2'b01};
        du    = r_v >>> r_cnt;
        dv    = r_u >>> r_cnt;
        tt    = signed'({4'b0000, turn_table(r_cnt)});

        if (r_cmd.trans_dead) begin
            mag_c = '0;
            ang   = '0;
        end else begin
            mag_c = (r_root > 16'd32768) ? 16'd32768 : r_root;
            ang   = r_acc[15:0];
        end
        twof = signed'({1'b0, ang[13:0], 1'b0});
        unique case (ang[15:14])
            2'd0: begin a_c = UNIT_Q14 - twof;  b_c = UNIT_Q14;         end
            2'd1: begin a_c = -UNIT_Q14;        b_c = UNIT_Q14 - twof;  end
            2'd2: begin a_c = -UNIT_Q14 + twof; b_c = -UNIT_Q14;        end
            default: begin a_c = UNIT_Q14;      b_c = -UNIT_Q14 + twof; end
        endcase
        s_c  = {1'b0, mag_c} + {1'b0, r_cmd.rmag};
        rr_w = r_cmd.r * signed'({1'b0, r_cmd.rmag});

        mult = r_blend ? signed'({1'b0, r_mm}) : signed'({17'd0, r_mag});

        // Right wheels take minus rotation, left wheels plus.
        num_c[0] = 50'(r_pa) - 50'(r_rt);
        num_c[1] = 50'(r_pb) - 50'(r_rt);
        num_c[2] = 50'(r_pa) + 50'(r_rt);
        num_c[3] = 50'(r_pb) + 50'(r_rt);
        for (int k = 0; k < 4; k++) begin
            n255[k] = (58'(num_c[k]) <<< 8) - 58'(num_c[k]);
            nabs[k] = n255[k][57] ? -n255[k] : n255[k];
        end
    end

    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_ITER;
                end
            end
            ST_ITER: if (r_cnt == CORDIC_LAST) n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_NUM;
            ST_NUM:  n_state = ST_DIV;
            ST_DIV:  if (r_cnt == DIV_LAST) n_state = ST_DONE;
            default: if (load_out) n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_cmd  <= i_cmd;
                r_cnt  <= '0;
                r_rad  <= sq_sum;
                r_rem  <= '0;
                r_root <= '0;
                if (u0 < 0) begin
                    r_u   <= -u0;
                    r_v   <= -v0;
                    r_acc <= 18'sd32768;
                end else begin
                    r_u   <= u0;
                    r_v   <= v0;
                    r_acc <= '0;
                end
            end
            ST_ITER: begin
                r_cnt <= r_cnt + 4'd1;
                r_rad <= {r_rad[29:0], 2'b00};
                if (rem_n >= trial) begin
                    r_rem  <= rem_n - trial;
                    r_root <= {r_root[14:0], 1'b1};
                end else begin
                    r_rem  <= rem_n;
                    r_root <= {r_root[14:0], 1'b0};
                end
                if (!r_v[33]) begin
                    r_u   <= r_u + du;
                    r_v   <= r_v - dv;
                    r_acc <= r_acc + tt;
                end else begin
                    r_u   <= r_u - du;
                    r_v   <= r_v + dv;
                    r_acc <= r_acc - tt;
                end
            end
            ST_MUL1: begin
                r_mag   <= mag_c;
                r_mm    <= mag_c * mag_c;
                r_rr    <= 32'(rr_w);
                r_a     <= a_c;
                r_b     <= b_c;
                r_blend <= s_c > {2'b00, i_dead_zone};
                r_s     <= (s_c > {2'b00, i_dead_zone}) ? s_c : 17'd1;
            end
            ST_MUL2: begin
                r_pa <= r_a * mult;
                r_pb <= r_b * mult;
                r_rt <= r_blend ? (46'(r_rr) <<< 14) : '0;
            end
            ST_NUM: begin
                r_cnt <= '0;
                r_dsh <= 53'(r_s) << 36;
                for (int k = 0; k < 4; k++) begin
                    r_num[k] <= nabs[k][56:0];
                    r_neg[k] <= n255[k][57];
                end
            end
            ST_DIV: begin
                r_cnt <= r_cnt + 4'd1;
                r_dsh <= r_dsh >> 1;
                for (int k = 0; k < 4; k++) begin
                    if (r_num[k] >= 57'(r_dsh)) begin
                        r_num[k] <= r_num[k] - 57'(r_dsh);
                        r_quo[k] <= {r_quo[k][6:0], 1'b1};
                    end else begin
                        r_quo[k] <= {r_quo[k][6:0], 1'b0};
                    end
                end
            end
            default: begin
                if (load_out) begin
                    for (int k = 0; k < 4; k++) begin
                        r_drive[k] <= r_neg[k] ? -signed'({1'b0, r_quo[k]})
                                               : signed'({1'b0, r_quo[k]});
                    end
                end
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;
endmodule

// File: hdl/mecanum_wheel_mixer.sv
// Mecanum wheel mixer: turns one stick word (x, y, rotation) into four wheel drive words.
// In the arithmetic back end each stick word passes a load step, the shared square-root and
// angle loop, the multiplies and numerators, the restoring divide that blends translation and
// rotation, and a hand-over to the output register. The front end registers and classifies the
// next word and a two-word queue holds further ones, so input and output stall independently;
// the back end takes no new word from the queue until it has handed the last to the output
// register. The user is to write the dead zone register only while the block is idle; the block
// itself does not enforce it. Its write channel is always ready.
module mecanum_wheel_mixer #(
    parameter int AXIS_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mwm_in_if.sink    i_in,
    mwm_out_if.source o_out,
    mwm_cfg_if.sink   i_cfg
);
    import mwm_pkg::*;

    logic [14:0]       r_dead_zone;
    logic              push, full, pop, empty;
    t_cmd              front_cmd, head_cmd;
    logic signed [8:0] drive [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DZ_RESET;
        end else if (i_cfg.valid) begin
            r_dead_zone <= i_cfg.dead_zone;
        end
    end
    assign i_cfg.ready = 1'b1;

    mwm_front #(.AXIS_BITS(AXIS_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_joy_x     (i_in.joy_x),
        .i_joy_y     (i_in.joy_y),
        .i_joy_r     (i_in.joy_r),
        .i_dead_zone (r_dead_zone),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .i_full      (full)
    );

    mwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    mwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dead_zone (r_dead_zone),
        .i_empty     (empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_drive     (drive)
    );

    assign o_out.drive_right_front = drive[0];
    assign o_out.drive_right_rear  = drive[1];
    assign o_out.drive_left_rear   = drive[2];
    assign o_out.drive_left_front  = drive[3];
endmodule

// File: hdl/mwm_checker.sv
// Port-level checks of the wheel mixer, bound to the top level.
`include "assert_macros.svh"

module mwm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic signed [8:0] i_rf,
    input logic signed [8:0] i_rr,
    input logic signed [8:0] i_lr,
    input logic signed [8:0] i_lf,
    input logic              i_cfg_ready
);
    // A drive word that is waiting must not change.
    `MWM_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rf) && $stable(i_rr) && $stable(i_lr) && $stable(i_lf), "drive word changed while stalled")
    // Truncation toward zero never reaches minus 256.
    `MWM_ASSERT(a_range, i_out_valid |-> i_rf != -9'sd256 && i_rr != -9'sd256 && i_lr != -9'sd256 && i_lf != -9'sd256, "drive value out of range")
    // Reset leaves no word on the output.
    `MWM_ASSERT_ALWAYS(a_reset_quiet, !$past(i_rst_n) |-> !i_out_valid, "output valid after reset")
    `MWM_ASSERT(a_cfg_ready, i_cfg_ready, "configuration channel not ready")
endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rf        (o_out.drive_right_front),
    .i_rr        (o_out.drive_right_rear),
    .i_lr        (o_out.drive_left_rear),
    .i_lf        (o_out.drive_left_front),
    .i_cfg_ready (i_cfg.ready)
);

// File: test/mwm_drive_checker.sv
// Checker of the wheel mixer: predicts the four drive words per stick word and compares them.
module mwm_drive_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mwm_in_if    i_in,
    mwm_out_if   i_out,
    mwm_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [8:0] rf;
        logic signed [8:0] rr;
        logic signed [8:0] lr;
        logic signed [8:0] lf;
    } t_drives;

    localparam int TURN_STEP[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1, 1, 0};

    logic [14:0] dz_copy;
    t_drives     drive_queue[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = drive_queue.size();

    function automatic longint stick_root(longint n);
        longint root;
        longint bitv;
        root = 0;
        bitv = longint'(1) <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    // Vectoring rotation; arithmetic shifts of signed values round toward minus infinity.
    function automatic logic [15:0] stick_heading(longint fwd, longint right);
        longint u, v, du, dv;
        int     acc;
        u   = fwd * 16384;
        v   = right * 16384;
        acc = 0;
        if (u < 0) begin
            u   = -u;
            v   = -v;
            acc = 32768;
        end
        for (int i = 0; i < 16; i++) begin
            du = v >>> i;
            dv = u >>> i;
            if (v >= 0) begin
                u   = u + du;
                v   = v - dv;
                acc = acc + TURN_STEP[i];
            end else begin
                u   = u - du;
                v   = v + dv;
                acc = acc - TURN_STEP[i];
            end
        end
        return acc[15:0];
    endfunction

    function automatic t_drives mix_drives(logic signed [15:0] jx, logic signed [15:0] jy,
                                           logic signed [15:0] jr, logic [14:0] dzone);
        longint      x, y, r, dz, mag, rmag, a, b, f, num, den, val;
        longint      pair[4];
        longint      rot[4];
        logic [15:0] ang;
        logic [8:0]  res[4];
        t_drives     d;
        x  = jx;
        y  = jy;
        r  = jr;
        dz = dzone;
        if ((x < 0 ? -x : x) < dz && (y < 0 ? -y : y) < dz) begin
            mag = 0;
            ang = 0;
        end else begin
            mag = stick_root(x * x + y * y);
            if (mag > 32768) mag = 32768;
            ang = stick_heading(-y, x);
        end
        rmag = r < 0 ? -r : r;
        if (rmag < dz) begin
            r    = 0;
            rmag = 0;
        end
        f = ang[13:0];
        case (ang[15:14])
            2'd0: begin a = 16384 - 2 * f;  b = 16384;          end
            2'd1: begin a = -16384;         b = 16384 - 2 * f;  end
            2'd2: begin a = -16384 + 2 * f; b = -16384;         end
            default: begin a = 16384;       b = -16384 + 2 * f; end
        endcase
        pair = '{a, b, a, b};
        rot  = '{-r, -r, r, r};
        for (int k = 0; k < 4; k++) begin
            if (mag + rmag > dz) begin
                num = pair[k] * mag * mag + rot[k] * rmag * 16384;
                den = (mag + rmag) * (longint'(1) <<< 29);
                val = (255 * num) / den;
            end else begin
                val = (255 * pair[k] * mag) / (longint'(1) <<< 29);
            end
            res[k] = val[8:0];
        end
        d.rf = res[0];
        d.rr = res[1];
        d.lr = res[2];
        d.lf = res[3];
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_drives want;
        if (!i_rst_n) begin
            dz_copy = mwm_pkg::DZ_RESET;
            drive_queue.delete();
            errors = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) dz_copy = i_cfg.dead_zone;
            if (i_in.valid && i_in.ready)
                drive_queue.push_back(mix_drives(i_in.joy_x, i_in.joy_y, i_in.joy_r, dz_copy));
            if (i_out.valid && i_out.ready) begin
                if (drive_queue.size() == 0) begin
                    $error("drive word with no stick word outstanding");
                    errors++;
                end else begin
                    want = drive_queue.pop_front();
                    if (i_out.drive_right_front !== want.rf) begin
                        $error("drive_right_front: expected %0d, got %0d", want.rf,
                               i_out.drive_right_front);
                        errors++;
                    end
                    if (i_out.drive_right_rear !== want.rr) begin
                        $error("drive_right_rear: expected %0d, got %0d", want.rr,
                               i_out.drive_right_rear);
                        errors++;
                    end
                    if (i_out.drive_left_rear !== want.lr) begin
                        $error("drive_left_rear: expected %0d, got %0d", want.lr,
                               i_out.drive_left_rear);
                        errors++;
                    end
                    if (i_out.drive_left_front !== want.lf) begin
                        $error("drive_left_front: expected %0d, got %0d", want.lf,
                               i_out.drive_left_front);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

// File: test/tb_mecanum_wheel_mixer.sv
// Top of the wheel mixer testbench: clock, reset, stick and dead zone stimulus, verdict.
module tb_mecanum_wheel_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1100;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   words_sent;
    int   dz_writes;
    int   stall_mode;

    mwm_in_if #(.AXIS_BITS(16)) in_ch ();
    mwm_out_if                  out_ch ();
    mwm_cfg_if                  cfg_ch ();

    mecanum_wheel_mixer #(.AXIS_BITS(16)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    mwm_drive_checker checker_inst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch),
        .i_out    (out_ch),
        .i_cfg    (cfg_ch),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // Receiver back-pressure: modes of no stall, light stall and heavy stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_mode = 0;
        end else begin
            if ($urandom_range(199) == 0) stall_mode = $urandom_range(2);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(3) != 0);
                default: out_ch.ready <= ($urandom_range(9) == 0);
            endcase
        end
    end

    task automatic send_stick(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] r);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.joy_x <= x;
        in_ch.joy_y <= y;
        in_ch.joy_r <= r;
        forever begin
            @(negedge i_clk);
            if (in_ch.ready) break;
        end
        @(posedge i_clk);
        words_sent++;
        gap = gap_length();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The dead zone is only changed once every drive word has come back.
    task automatic write_dead_zone(logic [14:0] dz);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.dead_zone <= dz;
        forever begin
            @(negedge i_clk);
            if (cfg_ch.ready) break;
        end
        @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        dz_writes++;
    endtask

    function automatic logic signed [15:0] axis_value(logic [14:0] dz);
        int pick;
        pick = $urandom_range(15);
        case (pick)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3: return $signed({1'b0, dz});
            4: return -$signed({1'b0, dz});
            5: return $signed({1'b0, dz}) - 16'sd1;
            6: return 16'sd1 - $signed({1'b0, dz});
            7: return $signed(16'($urandom_range(2 * dz + 2))) - $signed({1'b0, dz});
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [14:0] dz_plan[6];
        logic [14:0] dz;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.joy_x      = '0;
        in_ch.joy_y      = '0;
        in_ch.joy_r      = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.dead_zone = '0;
        words_sent       = 0;
        dz_writes        = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset dead zone.
        dz = mwm_pkg::DZ_RESET;
        send_stick(16'sd0, 16'sd0, 16'sd0);
        send_stick(16'sd0, 16'sh8000, 16'sd0);
        send_stick(16'sd0, 16'sh7fff, 16'sd0);
        send_stick(16'sh8000, 16'sd0, 16'sd0);
        send_stick(16'sh7fff, 16'sd0, 16'sd0);
        send_stick(16'sh8000, 16'sh8000, 16'sh8000);
        send_stick(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_stick(16'sh7fff, 16'sh8000, 16'sd0);
        send_stick(16'sh8000, 16'sh7fff, 16'sd0);
        send_stick(16'sd4914, -16'sd4914, 16'sd0);
        send_stick(16'sd4915, 16'sd0, 16'sd0);
        send_stick(16'sd0, -16'sd4915, 16'sd4914);
        send_stick(16'sd0, 16'sd0, 16'sd4915);
        send_stick(16'sd0, 16'sd0, -16'sd4915);
        send_stick(16'sd0, 16'sd0, 16'sh7fff);
        send_stick(16'sd0, 16'sd4915, 16'sh8000);
        send_stick(16'sd20000, -16'sd20000, 16'sd10000);
        send_stick(-16'sd20000, 16'sd20000, -16'sd10000);
        send_stick(16'sd0, -16'sd32767, 16'sd32767);

        // Dead zone at its largest and at zero, with magnitude plus rotation at and above it.
        write_dead_zone(15'd32767);
        send_stick(16'sd0, 16'sd0, 16'sh7fff);
        send_stick(16'sh8000, 16'sh8000, 16'sd0);
        send_stick(16'sd32767, 16'sd100, 16'sh8000);
        write_dead_zone(15'd0);
        send_stick(16'sd0, 16'sd0, 16'sd0);
        send_stick(16'sd1, 16'sd0, -16'sd1);
        send_stick(16'sd0, -16'sd1, 16'sd0);

        dz_plan = '{15'd0, 15'd32767, 15'd1, mwm_pkg::DZ_RESET,
                    15'($urandom_range(32767)), 15'($urandom_range(8000))};
        for (int phase = 0; phase < 6; phase++) begin
            dz = dz_plan[phase];
            write_dead_zone(dz);
            for (int n = 0; n < RANDOM_WORDS / 6; n++) begin
                send_stick(axis_value(dz), axis_value(dz), axis_value(dz));
                // Let the pipeline empty completely once mid-phase.
                if (n == 90) begin
                    in_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d stick words over %0d dead zone settings, zero and full scale among them.",
                 words_sent, dz_writes + 1);
        $display("Every drive word was compared field by field with the predicted one.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
